FILE: src/mfhp_pkg.sv
// ----------------------------------------------------------------------------
// mfhp_pkg
// Shared types, constants and helpers for the MAC frame header parser.
// ----------------------------------------------------------------------------
package mfhp_pkg;

    // Default depth of the header store (first bytes of a frame kept).
    localparam int HEADER_BYTES_DEF = 24;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECURITY_ENABLED = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECURITY_LEVEL   = 1'd1;
    localparam int CFG_DATA_W = 3;

    // Addressing mode codes (frame control byte 1 masked with MODE_MASK).
    localparam logic [7:0] MODE_MASK     = 8'hCC;
    localparam logic [7:0] MODE_SDST_LSRC = 8'hC8;
    localparam logic [7:0] MODE_LDST_LSRC = 8'hCC;
    localparam logic [7:0] MODE_SRC_ONLY  = 8'h80;
    localparam logic [7:0] MODE_SDST_SSRC = 8'h88;
    localparam logic [7:0] MODE_LDST_SSRC = 8'h8C;

    // Frame control byte 0 bits.
    localparam logic [7:0] FC0_INTRA_PAN = 8'h40;
    localparam logic [7:0] FC0_SECURITY  = 8'h08;
    localparam logic [7:0] FC0_TYPE_MASK = 8'h07;
    localparam logic [7:0] BCAST_BYTE    = 8'hFF;

    // Frame type codes in frame control byte 0.
    localparam logic [2:0] FT_BEACON  = 3'd0;
    localparam logic [2:0] FT_DATA    = 3'd1;
    localparam logic [2:0] FT_COMMAND = 3'd3;

    // Packet type codes on the result.
    localparam logic [1:0] PT_DATA    = 2'd0;
    localparam logic [1:0] PT_COMMAND = 2'd1;
    localparam logic [1:0] PT_BEACON  = 2'd2;

    // Bytes added to the payload offset of a secured frame, and the footer size.
    localparam logic [7:0] SEC_HDR_BYTES = 8'd5;
    localparam logic [7:0] FOOTER_BYTES  = 8'd4;

    // Result packing, lowest bit first.
    localparam int OUT_FIELDS_W = 118;
    localparam int OUT_TDATA_W  = 120;

    // Completed frame handed from the capture stage to the decoder.
    typedef struct packed {
        logic [7:0] frame_len;    // total bytes, LQI and RSSI included
        logic       bad_len;      // too long or shorter than two bytes
        logic [7:0] link_quality;
        logic [7:0] signal_strength;
    } frame_end_t;

    // Bytes stripped from the payload length for a given security level.
    function automatic logic [4:0] sec_trim(input logic [2:0] level);
        logic [4:0] t;
        case (level)
            3'd1:       t = 5'd5;
            3'd2, 3'd5: t = 5'd21;
            3'd3, 3'd6: t = 5'd13;
            3'd4, 3'd7: t = 5'd9;
            default:    t = 5'd0;
        endcase
        return t;
    endfunction

endpackage

FILE: src/mfhp_capture.sv
// ----------------------------------------------------------------------------
// mfhp_capture
// Byte counter and header store; hands a finished frame to the decoder.
// ----------------------------------------------------------------------------
module mfhp_capture #(
    parameter int HEADER_BYTES = mfhp_pkg::HEADER_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // frame_byte
    input  logic                          s_tlast,   // last_byte
    output logic [HEADER_BYTES-1:0][7:0]  header,
    output logic                          end_valid,
    input  logic                          end_ready,
    output mfhp_pkg::frame_end_t          end_info
);
    import mfhp_pkg::*;

    localparam int IDX_W = $clog2(HEADER_BYTES);

    logic [7:0]                   count_reg, count_next;
    logic [7:0]                   prev_reg, prev_next;
    logic                         ovf_reg, ovf_next;
    logic                         end_valid_reg, end_valid_next;
    frame_end_t                   end_reg, end_next;
    logic [HEADER_BYTES-1:0][7:0] header_reg;
    logic                         s_acc;
    logic                         store_en;

    // The store may be overwritten only once the decoder has taken the frame.
    assign s_tready = !end_valid_reg || end_ready;
    assign s_acc    = s_tvalid && s_tready;
    assign store_en = s_acc && (count_reg < 8'(HEADER_BYTES));

    always_comb begin
        count_next     = count_reg;
        prev_next      = prev_reg;
        ovf_next       = ovf_reg;
        end_next       = end_reg;
        end_valid_next = end_valid_reg;
        if (end_ready) begin
            end_valid_next = 1'b0;
        end
        if (s_acc) begin
            if (s_tlast) begin
                end_next.frame_len       = count_reg + 8'd1;
                end_next.bad_len         = ovf_reg || (count_reg == 8'hFF)
                                           || (count_reg == 8'd0);
                end_next.link_quality    = prev_reg;
                end_next.signal_strength = s_tdata;
                end_valid_next           = 1'b1;
                count_next               = 8'd0;
                prev_next                = 8'd0;
                ovf_next                 = 1'b0;
            end else begin
                if (count_reg == 8'hFF) begin
                    ovf_next = 1'b1;
                end else begin
                    count_next = count_reg + 8'd1;
                end
                prev_next = s_tdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= 8'd0;
            prev_reg      <= 8'd0;
            ovf_reg       <= 1'b0;
            end_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            prev_reg      <= prev_next;
            ovf_reg       <= ovf_next;
            end_valid_reg <= end_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        end_reg <= end_next;
        if (store_en) begin
            header_reg[count_reg[IDX_W-1:0]] <= s_tdata;
        end
    end

    assign header    = header_reg;
    assign end_valid = end_valid_reg;
    assign end_info  = end_reg;

`ifndef SYNTHESIS
    a_count_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> count_reg == 8'd0 && !ovf_reg && end_valid_reg)
        else $error("count not cleared after final byte");

    a_ovf_only_at_max: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ovf_reg) |-> $past(count_reg) == 8'hFF)
        else $error("overflow flagged below full count");
`endif

endmodule

FILE: src/mfhp_decode.sv
// ----------------------------------------------------------------------------
// mfhp_decode
// Decodes the stored header of a finished frame into the result register.
// ----------------------------------------------------------------------------
module mfhp_decode #(
    parameter int HEADER_BYTES = mfhp_pkg::HEADER_BYTES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [HEADER_BYTES-1:0][7:0]          header,
    input  logic                                  end_valid,
    output logic                                  end_ready,
    input  mfhp_pkg::frame_end_t                  end_info,
    input  logic                                  sec_en,
    input  logic [2:0]                            sec_level,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [mfhp_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import mfhp_pkg::*;

    logic [7:0]  fc0, mode;
    logic        intra, sec_bit, mode_ok, type_ok, is_short, bcast, too_short, keep;
    logic [15:0] pan;
    logic [63:0] addr;
    logic [4:0]  start, trim;
    logic [5:0]  need;
    logic [1:0]  ptype;
    logic [7:0]  offset, plen;
    logic [OUT_TDATA_W-1:0] data_next;
    logic [OUT_TDATA_W-1:0] data_reg;
    logic        valid_reg, valid_next;

    assign fc0     = header[0];
    assign mode    = header[1] & MODE_MASK;
    assign intra   = (fc0 & FC0_INTRA_PAN) != 8'd0;
    assign sec_bit = (fc0 & FC0_SECURITY) != 8'd0;

    always_comb begin
        mode_ok  = 1'b1;
        is_short = 1'b1;
        bcast    = 1'b0;
        pan      = {header[4], header[3]};
        addr     = 64'd0;
        start    = 5'd0;
        case (mode)
            MODE_SDST_LSRC: begin
                is_short = 1'b0;
                bcast    = (header[5] == BCAST_BYTE) && (header[6] == BCAST_BYTE);
                if (intra) begin
                    addr  = {header[14], header[13], header[12], header[11],
                             header[10], header[9], header[8], header[7]};
                    start = 5'd15;
                end else begin
                    pan   = {header[8], header[7]};
                    addr  = {header[16], header[15], header[14], header[13],
                             header[12], header[11], header[10], header[9]};
                    start = 5'd17;
                end
            end
            MODE_LDST_LSRC: begin
                is_short = 1'b0;
                if (intra) begin
                    addr  = {header[20], header[19], header[18], header[17],
                             header[16], header[15], header[14], header[13]};
                    start = 5'd21;
                end else begin
                    pan   = {header[14], header[13]};
                    addr  = {header[22], header[21], header[20], header[19],
                             header[18], header[17], header[16], header[15]};
                    start = 5'd23;
                end
            end
            MODE_SRC_ONLY: begin
                bcast = 1'b1;
                addr  = {48'd0, header[6], header[5]};
                start = 5'd7;
            end
            MODE_SDST_SSRC: begin
                bcast = (header[5] == BCAST_BYTE) && (header[6] == BCAST_BYTE);
                if (intra) begin
                    addr  = {48'd0, header[8], header[7]};
                    start = 5'd9;
                end else begin
                    pan   = {header[8], header[7]};
                    addr  = {48'd0, header[10], header[9]};
                    start = 5'd11;
                end
            end
            MODE_LDST_SSRC: begin
                if (intra) begin
                    addr  = {48'd0, header[14], header[13]};
                    start = 5'd15;
                end else begin
                    pan   = {header[14], header[13]};
                    addr  = {48'd0, header[16], header[15]};
                    start = 5'd17;
                end
            end
            default: begin
                mode_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        type_ok = 1'b1;
        case (fc0[2:0] & FC0_TYPE_MASK[2:0])
            FT_DATA:    ptype = PT_DATA;
            FT_COMMAND: ptype = PT_COMMAND;
            FT_BEACON:  ptype = PT_BEACON;
            default: begin
                ptype   = PT_DATA;
                type_ok = 1'b0;
            end
        endcase
    end

    assign trim      = sec_bit ? sec_trim(sec_level) : 5'd0;
    assign need      = 6'(start) + 6'(FOOTER_BYTES) + 6'(trim);
    assign too_short = end_info.frame_len < 8'(need);
    assign offset    = 8'(start) + (sec_bit ? SEC_HDR_BYTES : 8'd0);
    assign plen      = end_info.frame_len - 8'(start) - FOOTER_BYTES - 8'(trim);
    assign keep      = !end_info.bad_len && mode_ok && type_ok && !too_short
                       && !(sec_bit && !sec_en);

    always_comb begin
        data_next = '0;
        data_next[109:102] = end_info.link_quality;
        data_next[117:110] = end_info.signal_strength;
        if (keep) begin
            data_next[0]      = 1'b1;
            data_next[2:1]    = ptype;
            data_next[3]      = bcast;
            data_next[4]      = is_short;
            data_next[20:5]   = pan;
            data_next[84:21]  = addr;
            data_next[92:85]  = offset;
            data_next[100:93] = plen;
            data_next[101]    = sec_bit;
        end
    end

    // The result register frees itself as soon as the receiver takes it.
    assign end_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (end_ready) begin
            valid_next = end_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (end_ready && end_valid) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

`ifndef SYNTHESIS
    a_discard_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[101:1] == '0)
        else $error("discarded frame carries nonzero fields");

    a_offset_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[92:85] >= 8'd7)
        else $error("kept frame with impossible payload offset");
`endif

endmodule

FILE: src/mac_frame_header_parser_core.sv
// ----------------------------------------------------------------------------
// mac_frame_header_parser_core
// 802.15.4 MAC header parser: one result transaction per received frame.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries one frame byte per transaction, frame control first;
// s_tlast marks the final byte (RSSI), the byte before it being LQI.
// The m_ channel carries one result transaction per frame: kept or discarded,
// type, broadcast, source PAN id and address, payload offset and length,
// security flag, LQI and RSSI.
// Throughput is one byte per cycle while s_tready is high. After the final
// byte is accepted, the frame-end register in the capture stage is loaded,
// then the header decode writes the result register.
// While the result waits, bytes of the next frame are still taken; only when
// a second finished frame is waiting behind a stalled result does s_tready
// drop, so that the header store is not overwritten before it is decoded.
// Reset clears the byte count, the valid flags and both configuration
// registers; the header store keeps its contents and is only read at
// positions the current frame has written.
// Configuration (cfg_we, cfg_index, cfg_wdata) must be written only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module mac_frame_header_parser_core #(
    parameter int HEADER_BYTES = mfhp_pkg::HEADER_BYTES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [mfhp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mfhp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // frame_byte
    input  logic                                  s_tlast,   // last_byte
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // accepted, packet_type, broadcast, source_is_short, source_pan_id,
    // source_address, payload_offset, payload_length, secured,
    // link_quality, signal_strength, zero padding
    output logic [mfhp_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import mfhp_pkg::*;

    logic                         sec_en_reg, sec_en_next;
    logic [2:0]                   sec_level_reg, sec_level_next;
    logic [HEADER_BYTES-1:0][7:0] header;
    logic                         end_valid, end_ready;
    frame_end_t                   end_info;

    always_comb begin
        sec_en_next    = sec_en_reg;
        sec_level_next = sec_level_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_SECURITY_ENABLED: sec_en_next    = cfg_wdata[0];
                CFG_SECURITY_LEVEL:   sec_level_next = cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_en_reg    <= 1'b0;
            sec_level_reg <= 3'd0;
        end else begin
            sec_en_reg    <= sec_en_next;
            sec_level_reg <= sec_level_next;
        end
    end

    mfhp_capture #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_capture (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .header    (header),
        .end_valid (end_valid),
        .end_ready (end_ready),
        .end_info  (end_info)
    );

    mfhp_decode #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .header    (header),
        .end_valid (end_valid),
        .end_ready (end_ready),
        .end_info  (end_info),
        .sec_en    (sec_en_reg),
        .sec_level (sec_level_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready && end_valid)
        else $error("input stalled without a blocked result");
`endif

endmodule

FILE: tb/sv/mfhp_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mfhp_check_pkg
// Result layout and frame scoreboard for the MAC frame header parser bench.
// ----------------------------------------------------------------------------
package mfhp_check_pkg;

    import mfhp_pkg::*;

    // One result transaction, laid out as on m_tdata (lowest field last here).
    typedef struct packed {
        logic [1:0]  pad;
        logic [7:0]  signal_strength;
        logic [7:0]  link_quality;
        logic        secured;
        logic [7:0]  payload_length;
        logic [7:0]  payload_offset;
        logic [63:0] source_address;
        logic [15:0] source_pan_id;
        logic        source_is_short;
        logic        broadcast;
        logic [1:0]  packet_type;
        logic        accepted;
    } frame_summary_t;

    class frame_scoreboard;
        bit             sec_enabled;
        bit [2:0]       sec_level;
        bit [7:0]       byte_count;
        bit [7:0]       prev_byte;
        bit             overflow;
        bit [7:0]       header [HEADER_BYTES_DEF];
        frame_summary_t awaited [$];
        int             errors;
        int             frames_checked;
        int             frames_kept;

        function void clear();
            sec_enabled = 1'b0;
            sec_level   = 3'd0;
            byte_count  = 8'd0;
            prev_byte   = 8'd0;
            overflow    = 1'b0;
            awaited.delete();
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_SECURITY_ENABLED: sec_enabled = value[0];
                CFG_SECURITY_LEVEL:   sec_level = value[2:0];
                default: ;
            endcase
        endfunction

        // Header layout from the two frame control bytes. floor_len is the
        // shortest total length (LQI and RSSI included) that still parses.
        function bit layout(input bit [7:0] fc0, input bit [7:0] fc1,
                            output bit is_short, output int pan_at,
                            output int src_at, output int start,
                            output int floor_len);
            bit intra;
            int trim;
            intra     = (fc0 & FC0_INTRA_PAN) != 0;
            is_short  = 1'b1;
            pan_at    = 3;
            src_at    = 0;
            start     = 0;
            floor_len = 0;
            trim      = 0;
            case (fc1 & MODE_MASK)
                MODE_SDST_LSRC: begin
                    is_short = 1'b0;
                    pan_at   = intra ? 3 : 7;
                    src_at   = intra ? 7 : 9;
                    start    = intra ? 15 : 17;
                end
                MODE_LDST_LSRC: begin
                    is_short = 1'b0;
                    pan_at   = intra ? 3 : 13;
                    src_at   = intra ? 13 : 15;
                    start    = intra ? 21 : 23;
                end
                MODE_SRC_ONLY: begin
                    src_at = 5;
                    start  = 7;
                end
                MODE_SDST_SSRC: begin
                    pan_at = intra ? 3 : 7;
                    src_at = intra ? 7 : 9;
                    start  = intra ? 9 : 11;
                end
                MODE_LDST_SSRC: begin
                    pan_at = intra ? 3 : 13;
                    src_at = intra ? 13 : 15;
                    start  = intra ? 15 : 17;
                end
                default: return 1'b0;
            endcase
            if ((fc0 & FC0_SECURITY) != 0) begin
                // The level selects how many MIC and auxiliary header bytes go.
                case (sec_level)
                    3'd1:       trim = 5;
                    3'd2, 3'd5: trim = 21;
                    3'd3, 3'd6: trim = 13;
                    3'd4, 3'd7: trim = 9;
                    default:    trim = 0;
                endcase
            end
            floor_len = start + FOOTER_BYTES + trim;
            return 1'b1;
        endfunction

        function bit [7:0] hdr(int idx);
            return (idx < HEADER_BYTES_DEF) ? header[idx] : 8'h00;
        endfunction

        // Called for every accepted byte; a final byte queues one expectation.
        function void note_byte(bit [7:0] value, bit last);
            frame_summary_t r;
            int             n;
            int             pan_at;
            int             src_at;
            int             start;
            int             floor_len;
            bit             is_short;
            bit             secure;
            bit             keep;
            bit [1:0]       pkt;
            bit [7:0]       fc0;
            bit [7:0]       mode;
            if (byte_count < HEADER_BYTES_DEF)
                header[byte_count] = value;
            if (!last) begin
                if (byte_count == 8'hFF)
                    overflow = 1'b1;
                else
                    byte_count++;
                prev_byte = value;
                return;
            end

            n = byte_count + 1;
            r = '0;
            r.link_quality    = prev_byte;
            r.signal_strength = value;
            byte_count = 8'd0;
            prev_byte  = 8'd0;
            keep = !overflow && n >= 2 && n <= 255;
            overflow = 1'b0;

            // Header bytes are only looked at once the length is known to cover them.
            if (keep) begin
                fc0    = hdr(0);
                mode   = hdr(1) & MODE_MASK;
                secure = (fc0 & FC0_SECURITY) != 0;
                keep   = layout(fc0, hdr(1), is_short, pan_at, src_at, start, floor_len);
                if (keep && secure && !sec_enabled)
                    keep = 1'b0;
                if (keep && n < floor_len)
                    keep = 1'b0;
                if (keep) begin
                    case (fc0[2:0])
                        FT_DATA:    pkt = PT_DATA;
                        FT_COMMAND: pkt = PT_COMMAND;
                        FT_BEACON:  pkt = PT_BEACON;
                        default:    keep = 1'b0;
                    endcase
                end
            end

            if (keep) begin
                r.accepted        = 1'b1;
                r.packet_type     = pkt;
                r.source_is_short = is_short;
                if (mode == MODE_SRC_ONLY)
                    r.broadcast = 1'b1;
                else if (mode == MODE_SDST_LSRC || mode == MODE_SDST_SSRC)
                    r.broadcast = hdr(5) == BCAST_BYTE && hdr(6) == BCAST_BYTE;
                r.source_pan_id = {hdr(pan_at + 1), hdr(pan_at)};
                for (int k = 0; k < (is_short ? 2 : 8); k++)
                    r.source_address[8*k +: 8] = hdr(src_at + k);
                r.payload_offset = 8'(start + (secure ? SEC_HDR_BYTES : 8'd0));
                r.payload_length = 8'(n - floor_len);
                r.secured        = secure;
            end
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(frame_summary_t got);
            frame_summary_t want;
            if (awaited.size() == 0) begin
                $error("result transaction arrived with no frame outstanding");
                errors++;
                return;
            end
            want = awaited.pop_front();
            frames_checked++;
            if (want.accepted)
                frames_kept++;
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("packet_type", want.packet_type, got.packet_type);
            compare_field("broadcast", want.broadcast, got.broadcast);
            compare_field("source_is_short", want.source_is_short, got.source_is_short);
            compare_field("source_pan_id", want.source_pan_id, got.source_pan_id);
            compare_field("source_address", want.source_address, got.source_address);
            compare_field("payload_offset", want.payload_offset, got.payload_offset);
            compare_field("payload_length", want.payload_length, got.payload_length);
            compare_field("secured", want.secured, got.secured);
            compare_field("link_quality", want.link_quality, got.link_quality);
            compare_field("signal_strength", want.signal_strength, got.signal_strength);
        endfunction
    endclass

endpackage

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds 802.15.4 frames byte by byte into the header parser, first a directed
// set of corner frames, then random frames under twelve security settings,
// with random back-pressure on both channels save in the last stall mix, and
// checks every result transaction against a scoreboard prediction.
// ----------------------------------------------------------------------------
module testbench;

    import mfhp_pkg::*;
    import mfhp_check_pkg::*;

    localparam int STALL_LIMIT       = 5000;
    localparam int SETTLE_CYCLES     = 8;
    localparam int SETTINGS_COUNT    = 12;
    localparam int BYTES_PER_SETTING = 16;

    // Frame control values with no name in the package.
    localparam logic [7:0] MODE_NO_ADDR   = 8'h00;
    localparam logic [2:0] FT_RESERVED_LO = 3'd2;
    localparam logic [2:0] FT_RESERVED_HI = 3'd7;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [7:0]               s_tdata;
    logic                     s_tlast;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_TDATA_W-1:0]   m_tdata;

    frame_scoreboard sb;
    int              src_idle_pct  = 17;
    int              sink_idle_pct = 48;
    int              quiet_cycles  = 0;
    int              bytes_sent    = 0;
    int              frames_sent   = 0;
    logic [7:0]      frame_q [$];

    mac_frame_header_parser_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(frame_summary_t'(m_tdata));
    end

    // Ends the run if neither channel has moved a transaction for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_byte(value, last);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    task automatic fill_frame(input logic [7:0] fc0, input logic [7:0] fc1,
                              input int len, input bit dest_bcast);
        frame_q.delete();
        for (int i = 0; i < len; i++)
            frame_q.push_back(8'($urandom_range(255)));
        frame_q[0] = fc0;
        if (len > 1)
            frame_q[1] = fc1;
        if (dest_bcast && len > 6) begin
            frame_q[5] = BCAST_BYTE;
            frame_q[6] = BCAST_BYTE;
        end
    endtask

    task automatic fill_const(input logic [7:0] value, input int len);
        frame_q.delete();
        repeat (len)
            frame_q.push_back(value);
    endtask

    // Sends a frame whose length sits delta bytes from the shortest parsable one.
    task automatic floor_frame(input logic [7:0] fc0, input logic [7:0] fc1,
                               input int delta, input bit dest_bcast);
        bit is_short;
        int pan_at;
        int src_at;
        int start;
        int floor_len;
        if (!sb.layout(fc0, fc1, is_short, pan_at, src_at, start, floor_len))
            floor_len = 20;
        fill_frame(fc0, fc1, floor_len + delta, dest_bcast);
        send_frame();
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES)
            @(negedge aclk);
    endtask

    task automatic apply_setting(input bit enable, input logic [2:0] level);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SECURITY_ENABLED;
        cfg_wdata <= CFG_DATA_W'(enable);
        sb.write_register(CFG_SECURITY_ENABLED, CFG_DATA_W'(enable));
        @(negedge aclk);
        cfg_index <= CFG_SECURITY_LEVEL;
        cfg_wdata <= level;
        sb.write_register(CFG_SECURITY_LEVEL, level);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Mostly well-formed frames with random content, some noise and some
    // frames cut short or run past the length limit.
    task automatic random_frame();
        logic [7:0] fc0;
        logic [7:0] fc1;
        bit         is_short;
        int         pan_at;
        int         src_at;
        int         start;
        int         floor_len;
        int         len;
        int         pick;
        pick = $urandom_range(99);
        fc0  = 8'($urandom_range(255));
        fc1  = 8'($urandom_range(255));
        if (pick < 8) begin
            fill_frame(fc0, fc1, $urandom_range(1, 40), 1'b0);
        end else begin
            if (pick >= 12) begin
                fc1 = fc1 & ~MODE_MASK;
                case ($urandom_range(4))
                    0: fc1 = fc1 | MODE_SDST_LSRC;
                    1: fc1 = fc1 | MODE_LDST_LSRC;
                    2: fc1 = fc1 | MODE_SRC_ONLY;
                    3: fc1 = fc1 | MODE_SDST_SSRC;
                    default: fc1 = fc1 | MODE_LDST_SSRC;
                endcase
            end
            if ($urandom_range(99) < 85) begin
                case ($urandom_range(2))
                    0: fc0[2:0] = FT_DATA;
                    1: fc0[2:0] = FT_COMMAND;
                    default: fc0[2:0] = FT_BEACON;
                endcase
            end
            if ($urandom_range(99) < (sb.sec_enabled ? 40 : 12))
                fc0 = fc0 | FC0_SECURITY;
            else
                fc0 = fc0 & ~FC0_SECURITY;
            if (!sb.layout(fc0, fc1, is_short, pan_at, src_at, start, floor_len))
                floor_len = 20;
            pick = $urandom_range(99);
            if (pick < 70)
                len = floor_len + $urandom_range(0, 24);
            else if (pick < 84)
                len = $urandom_range(2, floor_len);
            else if (pick < 98)
                len = floor_len;
            else
                len = $urandom_range(250, 262);
            fill_frame(fc0, fc1, len, 1'($urandom_range(1)));
            // Occasionally only half of the destination looks like broadcast.
            if (len > 6 && $urandom_range(7) == 0)
                frame_q[5] = BCAST_BYTE;
        end
        send_frame();
    endtask

    initial begin
        int seg_start;
        sb = new();
        sb.clear();
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        repeat (6)
            @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed frames: lengths, every addressing mode, types and security.
        apply_setting(1'b0, 3'd0);
        fill_frame(8'(FT_DATA), MODE_SDST_SSRC, 1, 1'b0);
        send_frame();
        fill_frame(8'(FT_DATA), MODE_SDST_SSRC, 2, 1'b0);
        send_frame();
        floor_frame(FC0_INTRA_PAN | 8'(FT_DATA), MODE_SDST_LSRC, 0, 1'b0);
        floor_frame(8'(FT_COMMAND), MODE_LDST_LSRC, -1, 1'b0);
        floor_frame(8'(FT_BEACON), MODE_SRC_ONLY, 3, 1'b0);
        floor_frame(FC0_INTRA_PAN | 8'(FT_DATA), MODE_SDST_SSRC, 2, 1'b1);
        floor_frame(8'(FT_COMMAND), MODE_SDST_SSRC, 5, 1'b0);
        floor_frame(FC0_INTRA_PAN | 8'(FT_DATA), MODE_LDST_SSRC, 1, 1'b0);
        floor_frame(8'(FT_BEACON), MODE_LDST_SSRC, 0, 1'b0);
        floor_frame(8'(FT_DATA), MODE_SDST_LSRC, 4, 1'b1);
        floor_frame(FC0_INTRA_PAN | 8'(FT_COMMAND), MODE_LDST_LSRC, 0, 1'b0);
        floor_frame(8'(FT_DATA), MODE_NO_ADDR, 0, 1'b0);
        floor_frame(FC0_INTRA_PAN | 8'(FT_RESERVED_LO), MODE_SDST_SSRC, 2, 1'b0);
        floor_frame(8'(FT_RESERVED_HI), MODE_SDST_SSRC, 2, 1'b0);
        floor_frame(FC0_SECURITY | 8'(FT_DATA), MODE_SDST_SSRC, 2, 1'b0);
        fill_const(8'hFF, 30);
        send_frame();
        fill_const(8'h00, 30);
        send_frame();
        // Longest frame kept, one byte too many, and past the count limit.
        fill_frame(8'(FT_DATA), MODE_SDST_SSRC, 255, 1'b0);
        send_frame();
        fill_frame(8'(FT_DATA), MODE_SDST_SSRC, 256, 1'b0);
        send_frame();
        fill_frame(8'(FT_COMMAND), MODE_SDST_SSRC, 260, 1'b0);
        send_frame();
        apply_setting(1'b1, 3'd2);
        floor_frame(FC0_SECURITY | FC0_INTRA_PAN | 8'(FT_DATA), MODE_SDST_SSRC, 0, 1'b1);
        floor_frame(FC0_SECURITY | 8'(FT_COMMAND), MODE_LDST_LSRC, -1, 1'b0);
        apply_setting(1'b1, 3'd7);
        floor_frame(FC0_SECURITY | 8'(FT_DATA), MODE_SRC_ONLY, 0, 1'b0);
        apply_setting(1'b1, 3'd0);
        floor_frame(FC0_SECURITY | FC0_INTRA_PAN | 8'(FT_BEACON), MODE_LDST_SSRC, 1, 1'b0);

        // Random frames: each flow-control mix runs over four security settings.
        for (int seg = 0; seg < SETTINGS_COUNT; seg++) begin
            if (seg == 4) begin
                src_idle_pct  = 48;
                sink_idle_pct = 17;
            end else if (seg == 8) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            apply_setting(seg != 0 && seg != 9, 3'(seg % 8));
            seg_start = bytes_sent;
            while (bytes_sent - seg_start < BYTES_PER_SETTING) begin
                random_frame();
                if ($urandom_range(9) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        $display("Sent %0d frames in %0d bytes; %0d results checked, %0d parsed and %0d discarded.",
                 frames_sent, bytes_sent, sb.frames_checked, sb.frames_kept,
                 sb.frames_checked - sb.frames_kept);
        $display("Covered all addressing modes, frame types, every security level and three stall mixes.");
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
src/mfhp_pkg.sv
src/mfhp_capture.sv
src/mfhp_decode.sv
src/mac_frame_header_parser_core.sv
tb/sv/mfhp_check_pkg.sv
tb/sv/testbench.sv
